// ===== hw/rtl/lrps_pkg.sv =====
package lrps_pkg;

	localparam int STATE_W = 9;
	localparam int SYM_W   = 7;
	localparam int PROD_W  = 8;
	localparam int LEN_W   = 4;
	localparam int KIND_W  = 3;
	localparam int SIU_W   = 8;

	localparam logic [SIU_W-1:0] SIU_RESET = 8'd128;

	typedef enum logic [1:0] {
		CMD_PARSE,
		CMD_LOAD_ACTION,
		CMD_LOAD_PROD,
		CMD_CLEAR
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		ACT_ERROR  = 3'd0,
		ACT_SHIFT  = 3'd1,
		ACT_REDUCE = 3'd2,
		ACT_ACCEPT = 3'd3,
		ACT_GOTO   = 3'd4
	} act_kind_t;

	typedef enum logic [2:0] {
		EV_ERROR,
		EV_SHIFTED,
		EV_REDUCED,
		EV_ACCEPTED,
		EV_BAD_SYMBOL,
		EV_BAD_GOTO,
		EV_STACK_FAULT,
		EV_DONE
	} ev_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOP,
		ST_ACTION,
		ST_PROD,
		ST_PRE,
		ST_GOTO,
		ST_EMIT
	} fsm_t;

	typedef struct packed {
		ev_kind_t             kind;
		logic [STATE_W-1:0]   new_state;
		logic [SYM_W-1:0]     symbol;
		logic [PROD_W-1:0]    production;
		logic [STATE_W-1:0]   top_state;
	} event_t;

	function automatic event_t make_event(
		input ev_kind_t           kind,
		input logic [STATE_W-1:0] new_state,
		input logic [SYM_W-1:0]   symbol,
		input logic [PROD_W-1:0]  production,
		input logic [STATE_W-1:0] top_state
	);
		event_t e;
		e.kind       = kind;
		e.new_state  = new_state;
		e.symbol     = symbol;
		e.production = production;
		e.top_state  = top_state;
		return e;
	endfunction

endpackage

// ===== hw/rtl/lrps_in_if.sv =====
interface lrps_in_if;
	logic                            valid;
	logic                            ready;
	lrps_pkg::cmd_t                  cmd;
	logic [lrps_pkg::SYM_W-1:0]      symbol_code;
	logic [lrps_pkg::STATE_W-1:0]    table_row_state;
	logic [lrps_pkg::KIND_W-1:0]     action_kind;
	logic [lrps_pkg::STATE_W-1:0]    action_target;
	logic [lrps_pkg::PROD_W-1:0]     production_number;
	logic [lrps_pkg::SYM_W-1:0]      production_head;
	logic [lrps_pkg::LEN_W-1:0]      production_length;

	modport source (
		output valid, cmd, symbol_code, table_row_state, action_kind, action_target,
			production_number, production_head, production_length,
		input ready
	);

	modport sink (
		input valid, cmd, symbol_code, table_row_state, action_kind, action_target,
			production_number, production_head, production_length,
		output ready
	);
endinterface

// ===== hw/rtl/lrps_out_if.sv =====
interface lrps_out_if;
	logic                            valid;
	logic                            ready;
	lrps_pkg::ev_kind_t              event_kind;
	logic [lrps_pkg::STATE_W-1:0]    new_state;
	logic [lrps_pkg::SYM_W-1:0]      event_symbol;
	logic [lrps_pkg::PROD_W-1:0]     reduced_production;
	logic [lrps_pkg::STATE_W-1:0]    top_state_seen;

	modport source (
		output valid, event_kind, new_state, event_symbol, reduced_production, top_state_seen,
		input ready
	);

	modport sink (
		input valid, event_kind, new_state, event_symbol, reduced_production, top_state_seen,
		output ready
	);
endinterface

// ===== hw/rtl/lrps_ram.sv =====
module lrps_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/lrps_ctrl.sv =====
module lrps_ctrl #(
	parameter int STACK_DEPTH     = 256,
	parameter int NUM_STATES      = 512,
	parameter int NUM_SYMBOLS     = 128,
	parameter int NUM_PRODUCTIONS = 256,
	parameter int MAX_BODY        = 15,
	localparam int AA_W    = $clog2(NUM_STATES * NUM_SYMBOLS),
	localparam int PIDX_W  = $clog2(NUM_PRODUCTIONS),
	localparam int SADDR_W = $clog2(STACK_DEPTH),
	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1),
	localparam int LB_W    = $clog2(MAX_BODY + 1),
	localparam int ACT_W   = lrps_pkg::KIND_W + lrps_pkg::STATE_W,
	localparam int PRD_W   = lrps_pkg::SYM_W + LB_W,
	localparam int STK_W   = lrps_pkg::SYM_W + lrps_pkg::STATE_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lrps_in_if.sink                    items,
	lrps_out_if.source                 events,
	input  logic                       cfg_we,
	input  logic [lrps_pkg::SIU_W-1:0] cfg_wdata,
	output logic                       act_we,
	output logic [AA_W-1:0]            act_waddr,
	output logic [ACT_W-1:0]           act_wdata,
	output logic [AA_W-1:0]            act_raddr,
	input  logic [ACT_W-1:0]           act_rdata,
	output logic                       prod_we,
	output logic [PIDX_W-1:0]          prod_waddr,
	output logic [PRD_W-1:0]           prod_wdata,
	output logic [PIDX_W-1:0]          prod_raddr,
	input  logic [PRD_W-1:0]           prod_rdata,
	output logic                       stk_we,
	output logic [SADDR_W-1:0]         stk_waddr,
	output logic [STK_W-1:0]           stk_wdata,
	output logic [SADDR_W-1:0]         stk_raddr,
	input  logic [STK_W-1:0]           stk_rdata
);

	localparam int STATE_W = lrps_pkg::STATE_W;
	localparam int SYM_W   = lrps_pkg::SYM_W;
	localparam int PROD_W  = lrps_pkg::PROD_W;

	lrps_pkg::fsm_t             state_q, state_d;
	logic [DEPTH_W-1:0]         depth_q, depth_d;
	logic [lrps_pkg::SIU_W-1:0] siu_q;
	logic [SYM_W-1:0]           sym_q, sym_d;
	logic [STATE_W-1:0]         st_q, st_d;
	logic [STATE_W-1:0]         tgt_q, tgt_d;
	logic [SYM_W-1:0]           head_q, head_d;
	logic [DEPTH_W-1:0]         base_q, base_d;
	lrps_pkg::event_t           res_q, res_d;
	lrps_pkg::event_t           ev_q;
	logic                       out_valid_q;

	logic                       accept;
	logic                       out_free;
	logic                       ev_load;
	logic [STATE_W-1:0]         stk_state;
	logic [STATE_W-1:0]         top_st;
	logic [STATE_W-1:0]         pre_st;
	logic [STATE_W-1:0]         rd_row;
	logic [SYM_W-1:0]           rd_col;
	lrps_pkg::act_kind_t        act_kind;
	logic [STATE_W-1:0]         act_tgt;
	logic [SYM_W-1:0]           prod_head;
	logic [LB_W-1:0]            prod_len;
	logic [LB_W-1:0]            len_sat;
	int                         rem;

	assign items.ready = (state_q == lrps_pkg::ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign out_free    = !out_valid_q || events.ready;

	assign stk_state = stk_rdata[STATE_W-1:0];
	assign top_st    = (depth_q == '0) ? '0 : stk_state;
	assign pre_st    = (base_q == '0) ? '0 : stk_state;
	assign rd_row    = (state_q == lrps_pkg::ST_PRE) ? pre_st : top_st;
	assign rd_col    = (state_q == lrps_pkg::ST_PRE) ? head_q : sym_q;
	assign act_raddr = AA_W'(int'(rd_row) * NUM_SYMBOLS + int'(rd_col));

	assign act_kind  = lrps_pkg::act_kind_t'(act_rdata[ACT_W-1 -: lrps_pkg::KIND_W]);
	assign act_tgt   = act_rdata[STATE_W-1:0];
	assign prod_head = prod_rdata[LB_W +: SYM_W];
	assign prod_len  = prod_rdata[LB_W-1:0];
	assign rem       = int'(depth_q) - int'(prod_len);

	assign act_waddr = AA_W'(int'(items.table_row_state) * NUM_SYMBOLS +
		int'(items.symbol_code));
	assign act_wdata = {items.action_kind, items.action_target};

	assign len_sat    = (int'(items.production_length) > MAX_BODY) ? LB_W'(MAX_BODY)
		: LB_W'(items.production_length);
	assign prod_waddr = PIDX_W'(items.production_number);
	assign prod_wdata = {items.production_head, len_sat};
	assign prod_raddr = PIDX_W'(act_tgt);

	always_comb begin
		state_d   = state_q;
		depth_d   = depth_q;
		sym_d     = sym_q;
		st_d      = st_q;
		tgt_d     = tgt_q;
		head_d    = head_q;
		base_d    = base_q;
		res_d     = res_q;
		ev_load   = 1'b0;
		act_we    = 1'b0;
		prod_we   = 1'b0;
		stk_we    = 1'b0;
		stk_waddr = SADDR_W'(depth_q);
		stk_wdata = {sym_q, act_tgt};
		stk_raddr = SADDR_W'(int'(depth_q) - 1);

		unique case (state_q)
			lrps_pkg::ST_IDLE: begin
				if (accept) begin
					sym_d = items.symbol_code;
					res_d = lrps_pkg::make_event(lrps_pkg::EV_DONE, '0, '0, '0, '0);
					state_d = lrps_pkg::ST_EMIT;
					unique case (items.cmd)
						lrps_pkg::CMD_LOAD_ACTION: begin
							act_we = (int'(items.table_row_state) < NUM_STATES) &&
								(int'(items.symbol_code) < NUM_SYMBOLS);
						end
						lrps_pkg::CMD_LOAD_PROD: begin
							prod_we = int'(items.production_number) < NUM_PRODUCTIONS;
						end
						lrps_pkg::CMD_CLEAR: begin
							depth_d = '0;
						end
						lrps_pkg::CMD_PARSE: begin
							if (({1'b0, items.symbol_code} >= siu_q) ||
								(int'(items.symbol_code) >= NUM_SYMBOLS)) begin
								res_d = lrps_pkg::make_event(lrps_pkg::EV_BAD_SYMBOL,
									'0, '0, '0, '0);
							end else begin
								state_d = lrps_pkg::ST_TOP;
							end
						end
						default: begin
							state_d = lrps_pkg::ST_EMIT;
						end
					endcase
				end
			end
			lrps_pkg::ST_TOP: begin
				st_d = top_st;
				if (int'(top_st) >= NUM_STATES) begin
					res_d = lrps_pkg::make_event(lrps_pkg::EV_ERROR, '0, '0, '0, top_st);
					state_d = lrps_pkg::ST_EMIT;
				end else begin
					state_d = lrps_pkg::ST_ACTION;
				end
			end
			lrps_pkg::ST_ACTION: begin
				state_d = lrps_pkg::ST_EMIT;
				unique case (act_kind)
					lrps_pkg::ACT_SHIFT: begin
						if (int'(depth_q) >= STACK_DEPTH) begin
							res_d = lrps_pkg::make_event(lrps_pkg::EV_STACK_FAULT,
								'0, '0, '0, st_q);
						end else begin
							stk_we  = 1'b1;
							depth_d = depth_q + DEPTH_W'(1);
							res_d   = lrps_pkg::make_event(lrps_pkg::EV_SHIFTED,
								act_tgt, sym_q, '0, st_q);
						end
					end
					lrps_pkg::ACT_ACCEPT: begin
						res_d = lrps_pkg::make_event(lrps_pkg::EV_ACCEPTED, '0, '0, '0, st_q);
					end
					lrps_pkg::ACT_REDUCE: begin
						if (int'(act_tgt) >= NUM_PRODUCTIONS) begin
							res_d = lrps_pkg::make_event(lrps_pkg::EV_ERROR,
								'0, '0, '0, st_q);
						end else begin
							tgt_d   = act_tgt;
							state_d = lrps_pkg::ST_PROD;
						end
					end
					default: begin
						res_d = lrps_pkg::make_event(lrps_pkg::EV_ERROR, '0, '0, '0, st_q);
					end
				endcase
			end
			lrps_pkg::ST_PROD: begin
				head_d    = prod_head;
				stk_raddr = SADDR_W'(rem - 1);
				if ((rem < 0) || (rem >= STACK_DEPTH)) begin
					res_d = lrps_pkg::make_event(lrps_pkg::EV_STACK_FAULT,
						'0, '0, '0, st_q);
					state_d = lrps_pkg::ST_EMIT;
				end else begin
					base_d  = DEPTH_W'(rem);
					state_d = lrps_pkg::ST_PRE;
				end
			end
			lrps_pkg::ST_PRE: begin
				if ((int'(head_q) >= NUM_SYMBOLS) || (int'(pre_st) >= NUM_STATES)) begin
					res_d = lrps_pkg::make_event(lrps_pkg::EV_BAD_GOTO, '0, '0, '0, st_q);
					state_d = lrps_pkg::ST_EMIT;
				end else begin
					state_d = lrps_pkg::ST_GOTO;
				end
			end
			lrps_pkg::ST_GOTO: begin
				state_d   = lrps_pkg::ST_EMIT;
				stk_waddr = SADDR_W'(base_q);
				stk_wdata = {head_q, act_tgt};
				if (act_kind != lrps_pkg::ACT_GOTO) begin
					res_d = lrps_pkg::make_event(lrps_pkg::EV_BAD_GOTO, '0, '0, '0, st_q);
				end else begin
					stk_we  = 1'b1;
					depth_d = base_q + DEPTH_W'(1);
					res_d   = lrps_pkg::make_event(lrps_pkg::EV_REDUCED,
						act_tgt, head_q, PROD_W'(tgt_q), st_q);
				end
			end
			lrps_pkg::ST_EMIT: begin
				if (out_free) begin
					ev_load = 1'b1;
					state_d = lrps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lrps_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lrps_pkg::ST_IDLE;
			depth_q     <= '0;
			siu_q       <= lrps_pkg::SIU_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			if (cfg_we) begin
				siu_q <= cfg_wdata;
			end
			if (ev_load) begin
				out_valid_q <= 1'b1;
			end else if (events.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sym_q  <= sym_d;
		st_q   <= st_d;
		tgt_q  <= tgt_d;
		head_q <= head_d;
		base_q <= base_d;
		res_q  <= res_d;
		if (ev_load) begin
			ev_q <= res_q;
		end
	end

	assign events.valid              = out_valid_q;
	assign events.event_kind         = ev_q.kind;
	assign events.new_state          = ev_q.new_state;
	assign events.event_symbol       = ev_q.symbol;
	assign events.reduced_production = ev_q.production;
	assign events.top_state_seen     = ev_q.top_state;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(depth_q) <= STACK_DEPTH)
		else $error("Stack depth exceeds the stack size.");

	a_push_depth: assert property (@(posedge clk) disable iff (!arst_n)
		stk_we |=> (int'(depth_q) == int'($past(stk_waddr)) + 1))
		else $error("Stack depth does not follow the pushed entry.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != lrps_pkg::ST_IDLE))
		else $error("An accepted item left no work in flight.");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lrps_pkg::ST_EMIT && out_free) |=> events.valid)
		else $error("A finished event was not presented.");

	a_table_write: assert property (@(posedge clk) disable iff (!arst_n)
		(act_we || prod_we) |-> accept)
		else $error("A table write happened outside an item transfer.");

endmodule

// ===== hw/rtl/lr_parse_step_engine.sv =====
// Table-driven LR shift-reduce parser step engine.
// Items arrive on the items channel and each one yields exactly one event record on the
// events channel; both use valid/ready, and a transfer happens when both are high.
// Load items fill the action/goto table and the production table, a clear item empties
// the stack, and a parse item performs one shift, reduce, accept or error step.
// The user writes symbols-in-use via cfg_we/cfg_wdata while idle; this is not enforced.
// The engine works on one item at a time. Loads, clears and rejected symbols go straight
// to the emit state; shift, accept and most error steps pass the top and action states;
// a full reduce also passes the production, pre-goto and goto states, set by its chain of
// reads from synchronous memory: action entry, production entry, stack entry below the
// popped body, goto entry, each read registered.
// A finished event sits in an output register; when the receiver stalls, the engine holds
// the next event until that register frees, and then takes new items again.
// Reset empties the stack and sets symbols-in-use to 128; table contents are undefined
// until loaded and no clearing pass is run, so items are accepted right after reset.
module lr_parse_step_engine #(
	parameter int STACK_DEPTH     = 256,
	parameter int NUM_STATES      = 512,
	parameter int NUM_SYMBOLS     = 128,
	parameter int NUM_PRODUCTIONS = 256,
	parameter int MAX_BODY        = 15
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lrps_in_if.sink                    items,
	lrps_out_if.source                 events,
	input  logic                       cfg_we,
	input  logic [lrps_pkg::SIU_W-1:0] cfg_wdata
);

	localparam int ACT_DEPTH = NUM_STATES * NUM_SYMBOLS;
	localparam int AA_W      = $clog2(ACT_DEPTH);
	localparam int PIDX_W    = $clog2(NUM_PRODUCTIONS);
	localparam int SADDR_W   = $clog2(STACK_DEPTH);
	localparam int LB_W      = $clog2(MAX_BODY + 1);
	localparam int ACT_W     = lrps_pkg::KIND_W + lrps_pkg::STATE_W;
	localparam int PRD_W     = lrps_pkg::SYM_W + LB_W;
	localparam int STK_W     = lrps_pkg::SYM_W + lrps_pkg::STATE_W;

	logic               act_we;
	logic [AA_W-1:0]    act_waddr;
	logic [ACT_W-1:0]   act_wdata;
	logic [AA_W-1:0]    act_raddr;
	logic [ACT_W-1:0]   act_rdata;
	logic               prod_we;
	logic [PIDX_W-1:0]  prod_waddr;
	logic [PRD_W-1:0]   prod_wdata;
	logic [PIDX_W-1:0]  prod_raddr;
	logic [PRD_W-1:0]   prod_rdata;
	logic               stk_we;
	logic [SADDR_W-1:0] stk_waddr;
	logic [STK_W-1:0]   stk_wdata;
	logic [SADDR_W-1:0] stk_raddr;
	logic [STK_W-1:0]   stk_rdata;

	lrps_ctrl #(
		.STACK_DEPTH     (STACK_DEPTH),
		.NUM_STATES      (NUM_STATES),
		.NUM_SYMBOLS     (NUM_SYMBOLS),
		.NUM_PRODUCTIONS (NUM_PRODUCTIONS),
		.MAX_BODY        (MAX_BODY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.events     (events),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.act_we     (act_we),
		.act_waddr  (act_waddr),
		.act_wdata  (act_wdata),
		.act_raddr  (act_raddr),
		.act_rdata  (act_rdata),
		.prod_we    (prod_we),
		.prod_waddr (prod_waddr),
		.prod_wdata (prod_wdata),
		.prod_raddr (prod_raddr),
		.prod_rdata (prod_rdata),
		.stk_we     (stk_we),
		.stk_waddr  (stk_waddr),
		.stk_wdata  (stk_wdata),
		.stk_raddr  (stk_raddr),
		.stk_rdata  (stk_rdata)
	);

	lrps_ram #(
		.DEPTH (ACT_DEPTH),
		.WIDTH (ACT_W)
	) u_action_table (
		.clk   (clk),
		.we    (act_we),
		.waddr (act_waddr),
		.wdata (act_wdata),
		.raddr (act_raddr),
		.rdata (act_rdata)
	);

	lrps_ram #(
		.DEPTH (NUM_PRODUCTIONS),
		.WIDTH (PRD_W)
	) u_production_table (
		.clk   (clk),
		.we    (prod_we),
		.waddr (prod_waddr),
		.wdata (prod_wdata),
		.raddr (prod_raddr),
		.rdata (prod_rdata)
	);

	lrps_ram #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (STK_W)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

endmodule
